// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define IPOF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define IPOF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ipof_pkg.sv =====
// Package: types and constants for the integer power unit.
`timescale 1ns / 1ps
`default_nettype none

package ipof_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = DATA_W / 2;
    localparam int unsigned PROD_W = 2 * DATA_W;
    localparam int unsigned REST_W = DATA_W - 1;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_CHECK     = 6'b000010,
        S_WAIT_ACC  = 6'b000100,
        S_WAIT_SQ   = 6'b001000,
        S_WAIT_LAST = 6'b010000,
        S_DONE      = 6'b100000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // take a new beat: square = base, acc = 1, clear flag
        logic mul_go;   // launch the shared multiplier
        logic sel_acc;  // operand A is acc (else square); operand B is square
        logic wr_acc;   // write product into acc
        logic wr_sq;    // write product into square and shift exponent
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic rest_gt1;
        logic rest_eq1;
        logic rest_odd;
        logic mul_busy;
        logic mul_done;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hw/rtl/ipof_mul.sv =====
// Iterative 64x64 signed multiplier with wrap and overflow detection.
`timescale 1ns / 1ps
`default_nettype none

module ipof_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_go,
    input  wire logic [ipof_pkg::DATA_W-1:0]   i_a,
    input  wire logic [ipof_pkg::DATA_W-1:0]   i_b,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [ipof_pkg::DATA_W-1:0]        o_product,
    output logic                               o_ovf
);

    logic [ipof_pkg::DATA_W-1:0] r_mag_a, n_mag_a;
    logic [ipof_pkg::DATA_W-1:0] r_mag_b, n_mag_b;
    logic                        r_neg, n_neg;
    logic [ipof_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [1:0]                  r_step, n_step;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;

    logic [ipof_pkg::HALF_W-1:0] a_half;
    logic [ipof_pkg::HALF_W-1:0] b_half;
    logic [ipof_pkg::DATA_W-1:0] part;
    logic [ipof_pkg::PROD_W-1:0] part_sh;
    logic [ipof_pkg::DATA_W-1:0] limit;

    // Pick one 32x32 partial product per step
    assign a_half = r_step[1] ? r_mag_a[ipof_pkg::DATA_W-1:ipof_pkg::HALF_W]
                              : r_mag_a[ipof_pkg::HALF_W-1:0];
    assign b_half = r_step[0] ? r_mag_b[ipof_pkg::DATA_W-1:ipof_pkg::HALF_W]
                              : r_mag_b[ipof_pkg::HALF_W-1:0];
    assign part   = {{ipof_pkg::HALF_W{1'b0}}, a_half} * {{ipof_pkg::HALF_W{1'b0}}, b_half};

    // Align the partial product by its half weights
    always_comb begin
        case (r_step)
            2'd0: begin
                part_sh = {{ipof_pkg::DATA_W{1'b0}}, part};
            end
            2'd1, 2'd2: begin
                part_sh = {{ipof_pkg::HALF_W{1'b0}}, part, {ipof_pkg::HALF_W{1'b0}}};
            end
            default: begin
                part_sh = {part, {ipof_pkg::DATA_W{1'b0}}};
            end
        endcase
    end

    // Load magnitudes on go, then accumulate four partial products
    always_comb begin
        n_mag_a = r_mag_a;
        n_mag_b = r_mag_b;
        n_neg   = r_neg;
        n_prod  = r_prod;
        n_step  = r_step;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_go) begin
            n_mag_a = i_a[ipof_pkg::DATA_W-1]
                    ? (~i_a + {{(ipof_pkg::DATA_W-1){1'b0}}, 1'b1}) : i_a;
            n_mag_b = i_b[ipof_pkg::DATA_W-1]
                    ? (~i_b + {{(ipof_pkg::DATA_W-1){1'b0}}, 1'b1}) : i_b;
            n_neg   = i_a[ipof_pkg::DATA_W-1] ^ i_b[ipof_pkg::DATA_W-1];
            n_prod  = '0;
            n_step  = 2'd0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_prod = r_prod + part_sh;
            n_step = r_step + 2'd1;
            if (r_step == 2'd3) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control under reset, payload free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag_a <= n_mag_a;
        r_mag_b <= n_mag_b;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
    end

    // Magnitude limit: 2^63 for a negative result, 2^63-1 otherwise
    assign limit     = {r_neg, {(ipof_pkg::DATA_W-1){~r_neg}}};
    assign o_ovf     = (|r_prod[ipof_pkg::PROD_W-1:ipof_pkg::DATA_W]) ||
                       (r_prod[ipof_pkg::DATA_W-1:0] > limit);
    assign o_product = r_neg
                     ? (~r_prod[ipof_pkg::DATA_W-1:0] + {{(ipof_pkg::DATA_W-1){1'b0}}, 1'b1})
                     : r_prod[ipof_pkg::DATA_W-1:0];
    assign o_busy    = r_busy;
    assign o_done    = r_done;

endmodule

`default_nettype wire

// ===== hw/rtl/ipof_datapath.sv =====
// Datapath: accumulator, running square, exponent shifter and sticky flag.
`timescale 1ns / 1ps
`default_nettype none

module ipof_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ipof_pkg::t_dp_cmd             i_cmd,
    input  wire logic [ipof_pkg::DATA_W-1:0]   i_base,
    input  wire logic [ipof_pkg::DATA_W-1:0]   i_exponent,
    output ipof_pkg::t_dp_status               o_status,
    output logic [ipof_pkg::DATA_W-1:0]        o_power,
    output logic                               o_overflowed
);

    logic [ipof_pkg::DATA_W-1:0] r_acc, n_acc;
    logic [ipof_pkg::DATA_W-1:0] r_sq, n_sq;
    logic [ipof_pkg::REST_W-1:0] r_rest, n_rest;
    logic                        r_ovf, n_ovf;

    logic [ipof_pkg::DATA_W-1:0] mul_a;
    logic                        mul_busy;
    logic                        mul_done;
    logic [ipof_pkg::DATA_W-1:0] mul_product;
    logic                        mul_ovf;

    // Shared multiplier; operand B is always the running square
    assign mul_a = i_cmd.sel_acc ? r_acc : r_sq;

    ipof_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (i_cmd.mul_go),
        .i_a       (mul_a),
        .i_b       (r_sq),
        .o_busy    (mul_busy),
        .o_done    (mul_done),
        .o_product (mul_product),
        .o_ovf     (mul_ovf)
    );

    // Load a new beat or write back a finished product
    always_comb begin
        n_acc  = r_acc;
        n_sq   = r_sq;
        n_rest = r_rest;
        n_ovf  = r_ovf;
        if (i_cmd.load) begin
            n_acc  = {{(ipof_pkg::DATA_W-1){1'b0}}, 1'b1};
            n_sq   = i_base;
            n_rest = i_exponent[ipof_pkg::DATA_W-1] ? '0
                                                    : i_exponent[ipof_pkg::REST_W-1:0];
            n_ovf  = 1'b0;
        end else begin
            if (i_cmd.wr_acc) begin
                n_acc = mul_product;
                n_ovf = r_ovf | mul_ovf;
            end
            if (i_cmd.wr_sq) begin
                n_sq   = mul_product;
                n_rest = r_rest >> 1;
                n_ovf  = r_ovf | mul_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_rest <= n_rest;
        r_ovf  <= n_ovf;
    end

    // Report exponent and multiplier state
    assign o_status.rest_gt1 = |r_rest[ipof_pkg::REST_W-1:1];
    assign o_status.rest_eq1 = (r_rest == {{(ipof_pkg::REST_W-1){1'b0}}, 1'b1});
    assign o_status.rest_odd = r_rest[0];
    assign o_status.mul_busy = mul_busy;
    assign o_status.mul_done = mul_done;

    assign o_power      = r_acc;
    assign o_overflowed = r_ovf;

endmodule

`default_nettype wire

// ===== hw/rtl/ipof_ctrl.sv =====
// Controller: sequences square-and-multiply steps over the exponent bits.
`timescale 1ns / 1ps
`default_nettype none

module ipof_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire ipof_pkg::t_dp_status  i_status,
    output ipof_pkg::t_dp_cmd          o_cmd,
    output logic                       o_busy,
    output logic                       o_valid
);

    ipof_pkg::t_state r_state, n_state;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ipof_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ipof_pkg::S_CHECK;
                end
            end
            ipof_pkg::S_CHECK: begin
                if (i_status.rest_gt1) begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.sel_acc = i_status.rest_odd;
                    n_state = i_status.rest_odd ? ipof_pkg::S_WAIT_ACC
                                                : ipof_pkg::S_WAIT_SQ;
                end else if (i_status.rest_eq1) begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.sel_acc = 1'b1;
                    n_state       = ipof_pkg::S_WAIT_LAST;
                end else begin
                    n_state = ipof_pkg::S_DONE;
                end
            end
            ipof_pkg::S_WAIT_ACC: begin
                // write acc, then square with the same square value
                if (i_status.mul_done) begin
                    o_cmd.wr_acc = 1'b1;
                    o_cmd.mul_go = 1'b1;
                    n_state      = ipof_pkg::S_WAIT_SQ;
                end
            end
            ipof_pkg::S_WAIT_SQ: begin
                if (i_status.mul_done) begin
                    o_cmd.wr_sq = 1'b1;
                    n_state     = ipof_pkg::S_CHECK;
                end
            end
            ipof_pkg::S_WAIT_LAST: begin
                if (i_status.mul_done) begin
                    o_cmd.wr_acc = 1'b1;
                    n_state      = ipof_pkg::S_DONE;
                end
            end
            ipof_pkg::S_DONE: begin
                n_state = ipof_pkg::S_IDLE;
            end
            default: begin
                n_state = ipof_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipof_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != ipof_pkg::S_IDLE);
    assign o_valid = (r_state == ipof_pkg::S_DONE);

endmodule

`default_nettype wire

// ===== hw/rtl/int_power_overflow_flag.sv =====
// Top level: signed 64-bit integer power with sticky overflow flag.
// Usage:
//   Drive i_base and i_exponent and raise start; the beat is taken at a rising
//   edge where start is high and busy is low. busy stays high until the result
//   has been shown. The result appears on o_power and o_overflowed for exactly
//   one cycle, marked by o_valid; the receiver takes it then and cannot stall.
//   One shared multiplier does every product: a magnitude load, then four
//   32x32 partial products. Each exponent bit below the top set bit costs a
//   square, plus an acc multiply when the bit is set; the top bit costs one
//   acc multiply. A zero or negative exponent returns 1, going from S_CHECK
//   straight to S_DONE. One beat is in flight at a time.
//   o_overflowed is set when any product, squarings included, leaves the
//   signed 64-bit range; o_power is the product wrapped to 64 bits.
//   Synchronous active-low reset returns the controller to idle and drops any
//   beat in flight; no result is shown for it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module int_power_overflow_flag (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [ipof_pkg::DATA_W-1:0]   i_base,
    input  wire logic signed [ipof_pkg::DATA_W-1:0]   i_exponent,
    output logic                                      o_valid,
    output logic signed [ipof_pkg::DATA_W-1:0]        o_power,
    output logic                                      o_overflowed
);

    ipof_pkg::t_dp_cmd    cmd;
    ipof_pkg::t_dp_status status;
    logic [ipof_pkg::DATA_W-1:0] power_u;

    ipof_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    ipof_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_base       ($unsigned(i_base)),
        .i_exponent   ($unsigned(i_exponent)),
        .o_status     (status),
        .o_power      (power_u),
        .o_overflowed (o_overflowed)
    );

    assign o_power = $signed(power_u);

    // Checks on controller and multiplier sequencing
    `IPOF_ASSERT_IMP(a_go_idle_mul, cmd.mul_go, !status.mul_busy, "multiplier launched while busy")
    `IPOF_ASSERT_IMP(a_wr_on_done, cmd.wr_acc || cmd.wr_sq, status.mul_done, "write-back without product")
    `IPOF_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `IPOF_ASSERT_NXT(a_valid_pulse, o_valid, !o_valid && !busy, "result strobe not single cycle")

endmodule

`default_nettype wire
